// ===== hw/rtl/bui_pkg.sv =====
package bui_pkg;

   // Width of the configuration register index.
   localparam int CSR_INDEX_WIDTH = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_VERTEX_A = 3'd0,
      REG_VERTEX_B = 3'd1,
      REG_VERTEX_C = 3'd2,
      REG_UV_OF_A  = 3'd3,
      REG_UV_OF_B  = 3'd4,
      REG_UV_OF_C  = 3'd5
   } csr_reg_type;

   // The sub-areas must add up to the total within one part in this many.
   localparam int TOL_WIDTH = 14;
   localparam logic [TOL_WIDTH-1:0] TOL_RATIO = 14'd10000;

endpackage

// ===== hw/rtl/bui_isqrt.sv =====
module bui_isqrt #(
   parameter int ROOT_WIDTH = 35
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [2*ROOT_WIDTH-1:0] radicand,
   output logic [ROOT_WIDTH-1:0]   root
);

   // One result bit per stage: two radicand bits are shifted into the partial
   // remainder and the trial value four times the root plus one is subtracted.
   logic [2*ROOT_WIDTH-1:0] rad_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH:0]     rem_ff  [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0]   root_ff [ROOT_WIDTH];

   for (genvar s = 0; s < ROOT_WIDTH; s++) begin : g_stage
      logic [2*ROOT_WIDTH-1:0] rad_prev;
      logic [ROOT_WIDTH:0]     rem_prev;
      logic [ROOT_WIDTH-1:0]   root_prev;
      logic [ROOT_WIDTH+2:0]   cur;
      logic [ROOT_WIDTH+2:0]   trial;
      logic [ROOT_WIDTH+2:0]   diff;
      logic [2*ROOT_WIDTH-1:0] rad_in;
      logic [ROOT_WIDTH:0]     rem_in;
      logic [ROOT_WIDTH-1:0]   root_in;

      if (s == 0) begin : g_first
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      always_comb begin
         cur    = {rem_prev, rad_prev[2*ROOT_WIDTH-1 -: 2]};
         trial  = {1'b0, root_prev, 2'b01};
         diff   = cur - trial;
         rad_in = {rad_prev[2*ROOT_WIDTH-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in  = diff[ROOT_WIDTH:0];
            root_in = {root_prev[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = cur[ROOT_WIDTH:0];
            root_in = {root_prev[ROOT_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_in;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_WIDTH-1];

endmodule

// ===== hw/rtl/bui_area.sv =====
module bui_area #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [2:0][COORD_WIDTH-1:0] p,
   input  logic [2:0][COORD_WIDTH-1:0] q,
   input  logic [2:0][COORD_WIDTH-1:0] r,
   output logic [2*COORD_WIDTH+2:0]    area
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int RW = PW + 1;

   logic signed [DW-1:0] u_ff [3];
   logic signed [DW-1:0] v_ff [3];
   logic signed [DW-1:0] u_in [3];
   logic signed [DW-1:0] v_in [3];
   logic [PW:0]          c_ff [3];
   logic [PW:0]          c_in [3];
   logic [2*PW-1:0]      sq_ff [3];
   logic [2*PW-1:0]      sq_in [3];
   logic [2*PW+1:0]      sum_ff;
   logic [2*PW+1:0]      sum_in;

   // Edge vectors from the first corner.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = {q[k][COORD_WIDTH-1], q[k]} - {p[k][COORD_WIDTH-1], p[k]};
         v_in[k] = {r[k][COORD_WIDTH-1], r[k]} - {p[k][COORD_WIDTH-1], p[k]};
      end
   end

   // Cross product of the edge vectors.
   always_comb begin
      logic signed [PW-1:0] a0, b0, a1, b1, a2, b2;
      a0 = u_ff[1] * v_ff[2];
      b0 = u_ff[2] * v_ff[1];
      a1 = u_ff[2] * v_ff[0];
      b1 = u_ff[0] * v_ff[2];
      a2 = u_ff[0] * v_ff[1];
      b2 = u_ff[1] * v_ff[0];
      c_in[0] = {a0[PW-1], a0} - {b0[PW-1], b0};
      c_in[1] = {a1[PW-1], a1} - {b1[PW-1], b1};
      c_in[2] = {a2[PW-1], a2} - {b2[PW-1], b2};
   end

   // Squared magnitude of each component.
   always_comb begin
      logic [PW:0]   neg;
      logic [PW-1:0] mag;
      for (int k = 0; k < 3; k++) begin
         neg      = ~c_ff[k] + 1'b1;
         mag      = c_ff[k][PW] ? neg[PW-1:0] : c_ff[k][PW-1:0];
         sq_in[k] = (2*PW)'(mag) * (2*PW)'(mag);
      end
   end

   assign sum_in = (2*PW+2)'(sq_ff[0]) + (2*PW+2)'(sq_ff[1]) + (2*PW+2)'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         c_ff   <= c_in;
         sq_ff  <= sq_in;
         sum_ff <= sum_in;
      end
   end

   bui_isqrt #(
      .ROOT_WIDTH(RW)
   ) u_isqrt (
      .clock   (clock),
      .en      (en),
      .radicand(sum_ff),
      .root    (area)
   );

endmodule

// ===== hw/rtl/bui_div.sv =====
module bui_div #(
   parameter int NUM_WIDTH = 54,
   parameter int DEN_WIDTH = 35,
   parameter int QUO_WIDTH = 17
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [NUM_WIDTH-1:0] num,
   input  logic [DEN_WIDTH-1:0] den,
   output logic [QUO_WIDTH-1:0] quo
);

   // Restoring division, one quotient bit per stage from the top. The
   // numerator must be below the divisor shifted up by the quotient width.
   logic [NUM_WIDTH-1:0] rem_ff [QUO_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff [QUO_WIDTH];
   logic [QUO_WIDTH-1:0] quo_ff [QUO_WIDTH];

   for (genvar s = 0; s < QUO_WIDTH; s++) begin : g_stage
      localparam int SH = QUO_WIDTH - 1 - s;
      logic [NUM_WIDTH-1:0] rem_prev;
      logic [DEN_WIDTH-1:0] den_prev;
      logic [QUO_WIDTH-1:0] quo_prev;
      logic [NUM_WIDTH-1:0] shifted;
      logic [NUM_WIDTH-1:0] rem_in;
      logic [QUO_WIDTH-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      always_comb begin
         shifted = NUM_WIDTH'(den_prev) << SH;
         if (rem_prev >= shifted) begin
            rem_in = rem_prev - shifted;
            quo_in = {quo_prev[QUO_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_prev;
            quo_in = {quo_prev[QUO_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QUO_WIDTH-1];

endmodule

// ===== hw/rtl/barycentric_uv_interpolator_unit.sv =====
// Pipelined: takes one query word per cycle unless the receiver stalls the output;
// the pipeline depth is set by the bit-per-stage square root and the bit-per-stage divider.
// Reset is synchronous and active high: it clears the valid bits and the triangle and
// texture registers; the datapath registers are not reset.
module barycentric_uv_interpolator_unit #(
   parameter int COORD_WIDTH = 16,
   parameter int UV_WIDTH    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_WIDTH-1:0]        req_point_x,
   input  logic signed [COORD_WIDTH-1:0]        req_point_y,
   input  logic signed [COORD_WIDTH-1:0]        req_point_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [UV_WIDTH-1:0]                  rsp_tex_u,
   output logic [UV_WIDTH-1:0]                  rsp_tex_v,
   output logic                                 rsp_inside_res,
   input  logic                                 csr_we,
   input  logic [bui_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [((3*COORD_WIDTH > 2*UV_WIDTH) ? 3*COORD_WIDTH : 2*UV_WIDTH)-1:0] csr_data
);

   import bui_pkg::*;

   // Widths of the datapath, all derived from the coordinate and texture widths.
   localparam int RW  = 2 * COORD_WIDTH + 3;       // twice-area, square root width
   localparam int SW  = RW + 2;                    // sum of three sub-areas
   localparam int MW  = RW + UV_WIDTH;             // area times texture coordinate
   localparam int NW  = MW + 3;                    // weighted sum plus rounding term
   localparam int QB  = UV_WIDTH + 1;              // quotient bits, one for overshoot
   localparam int DTW = SW + TOL_WIDTH;            // scaled area mismatch
   localparam int NV  = 4 + RW + 2 + QB;           // stages ahead of the output word

   // Triangle and texture registers. The user is to change them only while the pipeline is
   // empty; the block itself does not enforce it. The stages that use them read them directly.
   logic [3*COORD_WIDTH-1:0] vtx_ff [3];
   logic [2*UV_WIDTH-1:0]    uv_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            vtx_ff[k] <= '0;
            uv_ff[k]  <= '0;
         end
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_VERTEX_A: vtx_ff[0] <= csr_data[3*COORD_WIDTH-1:0];
            REG_VERTEX_B: vtx_ff[1] <= csr_data[3*COORD_WIDTH-1:0];
            REG_VERTEX_C: vtx_ff[2] <= csr_data[3*COORD_WIDTH-1:0];
            REG_UV_OF_A:  uv_ff[0]  <= csr_data[2*UV_WIDTH-1:0];
            REG_UV_OF_B:  uv_ff[1]  <= csr_data[2*UV_WIDTH-1:0];
            REG_UV_OF_C:  uv_ff[2]  <= csr_data[2*UV_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves as one whenever the output register is free
   // or being emptied; a stall freezes every stage together so nothing is
   // dropped or repeated.
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Vertex and point coordinates as x, y, z vectors.
   logic [2:0][COORD_WIDTH-1:0] va, vb, vc, pt;

   assign va = vtx_ff[0];
   assign vb = vtx_ff[1];
   assign vc = vtx_ff[2];
   assign pt = {req_point_z, req_point_y, req_point_x};

   // Four twice-area lanes: the whole triangle and the three sub-triangles
   // that the query point makes with each edge.
   logic [RW-1:0] area_t, area_pab, area_pbc, area_pca;

   bui_area #(.COORD_WIDTH(COORD_WIDTH)) u_area_t (
      .clock(clock), .en(en), .p(va), .q(vb), .r(vc), .area(area_t)
   );
   bui_area #(.COORD_WIDTH(COORD_WIDTH)) u_area_pab (
      .clock(clock), .en(en), .p(pt), .q(va), .r(vb), .area(area_pab)
   );
   bui_area #(.COORD_WIDTH(COORD_WIDTH)) u_area_pbc (
      .clock(clock), .en(en), .p(pt), .q(vb), .r(vc), .area(area_pbc)
   );
   bui_area #(.COORD_WIDTH(COORD_WIDTH)) u_area_pca (
      .clock(clock), .en(en), .p(pt), .q(vc), .r(va), .area(area_pca)
   );

   // First stage after the areas: sum of the sub-areas and the six products
   // of a sub-area with a texture coordinate. Each vertex is weighted by the
   // area of the sub-triangle opposite it.
   logic [SW-1:0] s_ff, s_in;
   logic [RW-1:0] t1_ff;
   logic [MW-1:0] pu_ff [3];
   logic [MW-1:0] pv_ff [3];
   logic [MW-1:0] pu_in [3];
   logic [MW-1:0] pv_in [3];

   always_comb begin
      logic [RW-1:0] wt [3];
      wt[0] = area_pbc;
      wt[1] = area_pca;
      wt[2] = area_pab;
      s_in  = SW'(area_pab) + SW'(area_pbc) + SW'(area_pca);
      for (int k = 0; k < 3; k++) begin
         pu_in[k] = MW'(wt[k]) * MW'(uv_ff[k][UV_WIDTH-1:0]);
         pv_in[k] = MW'(wt[k]) * MW'(uv_ff[k][2*UV_WIDTH-1:UV_WIDTH]);
      end
   end

   // Second stage: mismatch between the total and the summed sub-areas, and
   // the weighted sums with half the total added so the division rounds
   // half up.
   logic [SW-1:0] d_ff, d_in;
   logic [RW-1:0] t2_ff;
   logic [NW-1:0] numu_ff, numv_ff, numu_in, numv_in;

   always_comb begin
      logic [SW-1:0] t_ext;
      t_ext   = SW'(t1_ff);
      d_in    = (s_ff >= t_ext) ? (s_ff - t_ext) : (t_ext - s_ff);
      numu_in = NW'(pu_ff[0]) + NW'(pu_ff[1]) + NW'(pu_ff[2]) + NW'(t1_ff >> 1);
      numv_in = NW'(pv_ff[0]) + NW'(pv_ff[1]) + NW'(pv_ff[2]) + NW'(t1_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in;
         t1_ff   <= area_t;
         pu_ff   <= pu_in;
         pv_ff   <= pv_in;
         d_ff    <= d_in;
         t2_ff   <= t1_ff;
         numu_ff <= numu_in;
         numv_ff <= numv_in;
      end
   end

   // The point is on the triangle when the triangle is not degenerate and
   // ten thousand times the mismatch stays below the total. Only then is the
   // weighted sum below the divisor times two to the quotient width, which
   // the divider relies on.
   logic [DTW-1:0] dtol;
   logic           inside_in;

   assign dtol      = DTW'(d_ff) * DTW'(TOL_RATIO);
   assign inside_in = (t2_ff != '0) && (dtol < DTW'(t2_ff));

   logic [QB-1:0] quo_u, quo_v;

   bui_div #(.NUM_WIDTH(NW), .DEN_WIDTH(RW), .QUO_WIDTH(QB)) u_div_u (
      .clock(clock), .en(en), .num(numu_ff), .den(t2_ff), .quo(quo_u)
   );
   bui_div #(.NUM_WIDTH(NW), .DEN_WIDTH(RW), .QUO_WIDTH(QB)) u_div_v (
      .clock(clock), .en(en), .num(numv_ff), .den(t2_ff), .quo(quo_v)
   );

   // The inside flag travels alongside the dividers.
   logic [QB-1:0] ins_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ins_ff <= {ins_ff[QB-2:0], inside_in};
      end
   end

   // Valid bits, one per stage, moving with the data.
   logic [NV-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[NV-2:0], req_valid};
         rsp_valid_ff <= vld_ff[NV-1];
      end
   end

   // Output word, zero when the point is outside. Weights may add up to slightly more than one
   // inside the tolerance, so a quotient that overflows the texture width saturates.
   logic [UV_WIDTH-1:0] tex_u_ff, tex_v_ff, tex_u_in, tex_v_in;
   logic                inside_ff;

   always_comb begin
      tex_u_in = quo_u[QB-1] ? {UV_WIDTH{1'b1}} : quo_u[UV_WIDTH-1:0];
      tex_v_in = quo_v[QB-1] ? {UV_WIDTH{1'b1}} : quo_v[UV_WIDTH-1:0];
      if (!ins_ff[QB-1]) begin
         tex_u_in = '0;
         tex_v_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tex_u_ff  <= tex_u_in;
         tex_v_ff  <= tex_v_in;
         inside_ff <= ins_ff[QB-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tex_u      = tex_u_ff;
   assign rsp_tex_v      = tex_v_ff;
   assign rsp_inside_res = inside_ff;

endmodule

// ===== dv/barycentric_uv_interpolator_unit_tb.sv =====
`timescale 1ns / 1ps

module barycentric_uv_interpolator_unit_tb;
   import bui_pkg::*;

   localparam int CW       = 16;
   localparam int UW       = 16;
   localparam int DW       = (3*CW > 2*UW) ? 3*CW : 2*UW;
   localparam int LATENCY  = 2*CW + UW + 11;
   localparam int SETTLE   = LATENCY + 10;
   localparam int MAX_CYCLES = 400000;
   localparam int LONG_HOLD  = 150;
   // Indexes past the last register; writes to them must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [UW-1:0] tex_u;
      logic [UW-1:0] tex_v;
      logic          in_tri;
   } uv_word_type;

   // Holds a copy of the triangle and texture registers, works out the
   // interpolated texture coordinate of every accepted query and compares it
   // with what the block returns, oldest first.
   class uv_scoreboard;
      logic [3*CW-1:0] vertex [3];
      logic [2*UW-1:0] uv     [3];
      uv_word_type     pending [$];
      int              errors;
      int              n_checked;
      int              n_inside;

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [DW-1:0] data);
         if (idx inside {[REG_VERTEX_A:REG_VERTEX_C]})
            vertex[2'(idx)] = data[3*CW-1:0];
         else if (idx inside {[REG_UV_OF_A:REG_UV_OF_C]})
            uv[2'(idx - REG_UV_OF_A)] = data[2*UW-1:0];
      endfunction

      function logic [63:0] floor_sqrt(logic [127:0] n);
         logic [63:0]  r;
         logic [63:0]  c;
         logic [127:0] sq;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= n)
               r = c;
         end
         return r;
      endfunction

      // Twice the area of triangle p, q, r: the rounded-down length of the
      // cross product of the edge vectors.
      function logic [63:0] double_area(longint p[3], longint q[3], longint r[3]);
         longint       e1 [3];
         longint       e2 [3];
         longint       cr [3];
         logic [127:0] s;
         logic [63:0]  m;
         for (int k = 0; k < 3; k++) begin
            e1[k] = q[k] - p[k];
            e2[k] = r[k] - p[k];
         end
         cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
         cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
         cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
         s = '0;
         for (int k = 0; k < 3; k++) begin
            m = (cr[k] < 0) ? -cr[k] : cr[k];
            s = s + {64'd0, m} * {64'd0, m};
         end
         return floor_sqrt(s);
      endfunction

      function void note_query(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
         longint       vt [3][3];
         longint       pt [3];
         logic [63:0]  t, pab, pbc, pca, s, d;
         logic [127:0] num;
         logic [127:0] q;
         logic [UW-1:0] res [2];
         uv_word_type  w;
         for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
               vt[k][j] = longint'($signed(vertex[k][j*CW +: CW]));
         pt[0] = longint'($signed(x));
         pt[1] = longint'($signed(y));
         pt[2] = longint'($signed(z));
         t   = double_area(vt[0], vt[1], vt[2]);
         pab = double_area(pt, vt[0], vt[1]);
         pbc = double_area(pt, vt[1], vt[2]);
         pca = double_area(pt, vt[2], vt[0]);
         s   = pab + pbc + pca;
         d   = (s >= t) ? s - t : t - s;
         w   = '0;
         if (t > 0 && d < (t + 64'd9999) / 64'd10000) begin
            for (int j = 0; j < 2; j++) begin
               num = {64'd0, pbc} * uv[0][j*UW +: UW]
                   + {64'd0, pca} * uv[1][j*UW +: UW]
                   + {64'd0, pab} * uv[2][j*UW +: UW]
                   + (t >> 1);
               q = num / {64'd0, t};
               res[j] = (q > {UW{1'b1}}) ? {UW{1'b1}} : q[UW-1:0];
            end
            w.tex_u  = res[0];
            w.tex_v  = res[1];
            w.in_tri = 1'b1;
         end
         pending.push_back(w);
      endfunction

      function void check_result(logic [UW-1:0] u, logic [UW-1:0] v, logic ins);
         uv_word_type e;
         if (pending.size() == 0) begin
            $error("result word with nothing expected: u=%h v=%h inside=%b", u, v, ins);
            errors++;
            return;
         end
         e = pending.pop_front();
         n_checked++;
         if (e.in_tri)
            n_inside++;
         if (u !== e.tex_u) begin
            $error("tex_u: expected %h, got %h", e.tex_u, u);
            errors++;
         end
         if (v !== e.tex_v) begin
            $error("tex_v: expected %h, got %h", e.tex_v, v);
            errors++;
         end
         if (ins !== e.in_tri) begin
            $error("inside_res: expected %b, got %b", e.in_tri, ins);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [CW-1:0]       req_point_x;
   logic signed [CW-1:0]       req_point_y;
   logic signed [CW-1:0]       req_point_z;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [UW-1:0]              rsp_tex_u;
   logic [UW-1:0]              rsp_tex_v;
   logic                       rsp_inside_res;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [DW-1:0]              csr_data;

   uv_scoreboard sb;
   bit           gaps_on;        // random idling on both sides
   bit           hold_request;   // asks the receiver for one long hold-off
   int           cycle_count;

   barycentric_uv_interpolator_unit #(.COORD_WIDTH(CW), .UV_WIDTH(UW)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tex_u      (rsp_tex_u),
      .rsp_tex_v      (rsp_tex_v),
      .rsp_inside_res (rsp_inside_res),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Both channels are sampled at the rising edge; the stimulus only ever
   // changes on the falling edge, so the sampled values are settled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_query(req_point_x, req_point_y, req_point_z);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_tex_u, rsp_tex_v, rsp_inside_res);
      end
   end

   // Watchdog: a hung handshake must not leave the run spinning for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver. Stalls come in short random bursts while idling is enabled;
   // on request it holds off for a long stretch so that the pipeline fills
   // and the block has to stall its own input.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall    <= 1'b0;
            hold_request  = 1'b0;
         end else if (gaps_on && !reset && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one query word and returns at the falling edge after it has been
   // taken. The payload holds still for as long as the block stalls.
   task automatic send_query(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drops valid, waits for every outstanding result and then for the
   // pipeline to settle, so that the registers may be changed safely.
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Loads a triangle; the spare high data bits are filled with noise, as
   // the block must ignore them.
   task automatic load_triangle(logic [3*CW-1:0] va, logic [3*CW-1:0] vb,
                                logic [3*CW-1:0] vc, logic [2*UW-1:0] ta,
                                logic [2*UW-1:0] tb, logic [2*UW-1:0] tc);
      logic [DW-1:0] noise;
      noise = DW'({$urandom, $urandom});
      write_csr(REG_VERTEX_A, va);
      write_csr(REG_VERTEX_B, vb);
      write_csr(REG_VERTEX_C, vc);
      write_csr(REG_UV_OF_A, {noise[DW-1:2*UW], ta});
      write_csr(REG_UV_OF_B, {noise[DW-1:2*UW], tb});
      write_csr(REG_UV_OF_C, {noise[DW-1:2*UW], tc});
   endtask

   function automatic logic [CW-1:0] rand_coord(int span);
      if (span >= 32768)
         return CW'($urandom);
      return CW'($urandom_range(0, 2*span) - span);
   endfunction

   function automatic logic [3*CW-1:0] rand_vertex(int span);
      return {rand_coord(span), rand_coord(span), rand_coord(span)};
   endfunction

   // Query near the plane of the triangle: a random weighted mean of the
   // three vertices. Truncation leaves it slightly off, which exercises
   // both sides of the tolerance on small triangles.
   task automatic send_blend;
      int w [3];
      int sum;
      int acc;
      logic [CW-1:0] c [3];
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         w[k] = $urandom_range(0, 255);
         sum += w[k];
      end
      if (sum == 0) begin
         w[0] = 1;
         sum  = 1;
      end
      for (int j = 0; j < 3; j++) begin
         acc = 0;
         for (int k = 0; k < 3; k++)
            acc += w[k] * int'($signed(sb.vertex[k][j*CW +: CW]));
         c[j] = CW'(acc / sum);
      end
      send_query(c[0], c[1], c[2]);
   endtask

   task automatic random_phase(int n_items, int span);
      load_triangle(rand_vertex(span), rand_vertex(span), rand_vertex(span),
                    $urandom, $urandom, $urandom);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 9) < 7)
            send_blend();
         else
            send_query(CW'($urandom), CW'($urandom), CW'($urandom));
      end
      drain();
   endtask

   initial begin
      logic [CW-1:0] lo;
      logic [CW-1:0] hi;
      logic [CW-1:0] zr;
      sb           = new();
      sb.errors    = 0;
      gaps_on      = 1'b0;
      hold_request = 1'b0;
      cycle_count  = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_point_x  = '0;
      req_point_y  = '0;
      req_point_z  = '0;
      csr_we       = 1'b0;
      csr_index    = REG_VERTEX_A;
      csr_data     = '0;
      lo = {1'b1, {CW-1{1'b0}}};
      hi = {1'b0, {CW-1{1'b1}}};
      zr = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Registers still hold their reset value: the triangle has no area, so
      // every query, even one on the vertices, must come back outside.
      send_query(zr, zr, zr);
      send_query(hi, hi, hi);
      send_query(lo, lo, lo);
      drain();

      // Largest right triangle in z = 0 with the texture extremes at its
      // corners: vertices, edge midpoints, centroid and far-off corners.
      load_triangle({zr, lo, lo}, {zr, lo, hi}, {zr, hi, lo},
                    32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FFFF);
      send_query(lo, lo, zr);
      send_query(hi, lo, zr);
      send_query(lo, hi, zr);
      send_query(zr, lo, zr);
      send_query(lo, zr, zr);
      send_query(zr, zr, zr);
      send_query(CW'(-10923), CW'(-10923), zr);
      send_query(hi, hi, zr);
      send_query(zr, zr, hi);
      send_query(zr, zr, lo);
      drain();

      // Writes to the unused indexes must not disturb the triangle.
      write_csr(CSR_SPARE_LO, {DW{1'b1}});
      write_csr(CSR_SPARE_HI, {DW{1'b1}});
      send_query(CW'(-16384), CW'(-16384), zr);
      send_query(hi, lo, zr);
      drain();

      // Collinear vertices: a degenerate triangle with the extremes of z.
      load_triangle({lo, zr, zr}, {zr, zr, zr}, {hi, zr, zr},
                    32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF);
      send_query(zr, zr, zr);
      send_query(lo, zr, zr);
      send_query(zr, zr, hi);
      drain();

      // Random triangles of every size, with idling on both sides. The third
      // phase asks for a long receiver hold-off while queries keep coming.
      gaps_on = 1'b1;
      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 2)
            hold_request = 1'b1;
         case (ph % 3)
            0: random_phase(60, 32768);
            1: random_phase(60, 2000);
            default: random_phase(60, 12);
         endcase
      end

      // Closing stretch at full rate on both sides.
      gaps_on = 1'b0;
      random_phase(90, 32768);

      if (sb.pending.size() != 0) begin
         $error("%0d result words never arrived", sb.pending.size());
         sb.errors++;
      end
      $display("Checked %0d result words (%0d inside) over 13 triangle settings,",
               sb.n_checked, sb.n_inside);
      $display("including degenerate and extreme triangles and a long output hold-off.");
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
